// ===== rtl/rle_sprite_alpha_blitter_assert.svh =====
// Assertion macros for the sprite blitter. Each macro expects clk_i and rst_ni in scope.
`ifndef RLE_SPRITE_ALPHA_BLITTER_ASSERT_SVH
`define RLE_SPRITE_ALPHA_BLITTER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define RSAB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define RSAB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RSAB_ASSERT_IMP(lbl, ante, cons, msg)
`define RSAB_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/rsab_pkg.sv =====
package rsab_pkg;

  // Input item modes.
  typedef enum logic [2:0] {
    MODE_PAL_WR = 3'd0,
    MODE_START  = 3'd1,
    MODE_WORD   = 3'd2,
    MODE_READ   = 3'd3,
    MODE_LOAD   = 3'd4
  } mode_e;

  // Work carried by the second stage.
  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_BLEND = 2'd1,
    OP_READ  = 2'd2,
    OP_LOAD  = 2'd3
  } op_e;

  // Header kinds in bits 15-14 of a stream word.
  localparam logic [1:0] KIND_PIXELS = 2'b00;
  localparam logic [1:0] KIND_LINES  = 2'b01;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_HEIGHT = 1'b1;

  localparam logic [8:0] TARGET_RESET = 9'd256;

  // Second stage control and payload.
  typedef struct packed {
    op_e         op;
    logic [7:0]  pix_x;
    logic [7:0]  pix_y;
    logic [3:0]  alpha;
    logic [7:0]  pal_idx;
    logic        pal_vld;
    logic [23:0] color;
  } s1_t;

  // One result item.
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] pix_y;
    logic [7:0] pix_x;
    logic       is_read;
  } res_t;

  // Per-channel blend (d*(15-a) + p*a) / 16; the sum stays below 4096.
  function automatic logic [7:0] mix8(logic [7:0] d, logic [7:0] p, logic [3:0] a);
    logic [11:0] s;
    s = 12'(d) * 12'(4'd15 - a) + 12'(p) * 12'(a);
    return s[11:4];
  endfunction

endpackage

// ===== rtl/rle_sprite_alpha_blitter.sv =====
// Channel   Direction  Transaction
// s_axis    in         one command: palette write, sprite start, stream word, read, load
// m_axis    out        one blended pixel report or one read response
// cfg       in         register write, no handshake
//
// One item is accepted per cycle while input ready is high. A result passes through the
// second stage register to the output register: the accepting edge issues the palette and
// framebuffer reads, and the edge that advances that stage blends, writes the framebuffer
// back and loads the output register. Reset clears the cursor, the palette valid bits and
// the pipeline; there is no clearing pass. Input ready drops only while a result waits in
// the second stage behind an output register that has not been taken.
`include "rle_sprite_alpha_blitter_assert.svh"
module rle_sprite_alpha_blitter #(
  parameter int FB_WIDTH_MAX  = 256,
  parameter int FB_HEIGHT_MAX = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // pal_index[7:0], color_value[31:8], pos_x[47:32], pos_y[63:48],
  // sprite_width[75:64], data_word[91:76], zero fill [95:92]
  input  logic [95:0] s_axis_tdata_i,
  // mode[2:0]
  input  logic [2:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // pix_x[7:0], pix_y[15:8], red[23:16], green[31:24], blue[39:32]
  output logic [39:0] m_axis_tdata_o,
  // is_read[0]
  output logic        m_axis_tuser_o,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [8:0]  cfg_data_i
);
  import rsab_pkg::*;

  localparam int FB_DEPTH = FB_WIDTH_MAX * FB_HEIGHT_MAX;
  localparam int AW       = $clog2(FB_DEPTH);

  logic [8:0] target_width_q, target_height_q;

  logic          accept;
  logic          s1_go;
  logic          pal_we;
  logic [7:0]    pal_waddr, pal_raddr;
  logic [23:0]   pal_wdata, pal_rdata;
  logic [AW-1:0] frame_raddr, s1_addr;
  logic [23:0]   frame_rdata;
  s1_t           s1;
  logic          wr;
  logic          frame_we;
  logic [23:0]   wdata;
  logic          res_vld;
  res_t          res;
  logic          fwd_q;
  logic [23:0]   fwd_data_q;
  logic          out_valid_q;
  res_t          out_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_width_q  <= TARGET_RESET;
      target_height_q <= TARGET_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TARGET_WIDTH:  target_width_q  <= cfg_data_i;
        CFG_TARGET_HEIGHT: target_height_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // The second stage moves unless its result meets a full output register that is not being taken.
  assign s1_go           = !res_vld || !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = s1_go;
  assign accept          = s_axis_tvalid_i && s1_go;
  assign frame_we        = s1_go && wr;

  rsab_front #(
    .FB_WIDTH_MAX  (FB_WIDTH_MAX),
    .FB_HEIGHT_MAX (FB_HEIGHT_MAX),
    .AW            (AW)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .adv_i           (s1_go),
    .mode_i          (s_axis_tuser_i),
    .pal_index_i     (s_axis_tdata_i[7:0]),
    .color_value_i   (s_axis_tdata_i[31:8]),
    .pos_x_i         (s_axis_tdata_i[47:32]),
    .pos_y_i         (s_axis_tdata_i[63:48]),
    .sprite_width_i  (s_axis_tdata_i[75:64]),
    .data_word_i     (s_axis_tdata_i[91:76]),
    .target_width_i  (target_width_q),
    .target_height_i (target_height_q),
    .pal_we_o        (pal_we),
    .pal_waddr_o     (pal_waddr),
    .pal_wdata_o     (pal_wdata),
    .pal_raddr_o     (pal_raddr),
    .frame_raddr_o   (frame_raddr),
    .s1_o            (s1),
    .s1_addr_o       (s1_addr)
  );

  rsab_ram #(
    .WIDTH (24),
    .DEPTH (256)
  ) u_pal_ram (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (pal_waddr),
    .wdata_i (pal_wdata),
    .re_i    (s1_go),
    .raddr_i (pal_raddr),
    .rdata_o (pal_rdata)
  );

  rsab_ram #(
    .WIDTH (24),
    .DEPTH (FB_DEPTH)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (frame_we),
    .waddr_i (s1_addr),
    .wdata_i (wdata),
    .re_i    (s1_go),
    .raddr_i (frame_raddr),
    .rdata_o (frame_rdata)
  );

  rsab_blend u_blend (
    .s1_i          (s1),
    .pal_rdata_i   (pal_rdata),
    .frame_rdata_i (frame_rdata),
    .fwd_i         (fwd_q),
    .fwd_data_i    (fwd_data_q),
    .wr_o          (wr),
    .wdata_o       (wdata),
    .res_vld_o     (res_vld),
    .res_o         (res)
  );

  // A read issued on the same edge as a write to that pixel sees stale data; forward it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (s1_go) begin
      fwd_q <= frame_we && (s1_addr == frame_raddr);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      fwd_data_q <= wdata;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go && res_vld) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && res_vld) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_q.blue, out_q.green, out_q.red, out_q.pix_y, out_q.pix_x};
  assign m_axis_tuser_o  = out_q.is_read;

  // Checks on the pipeline and forwarding.
  `RSAB_ASSERT_IMP(a_fwd_from_write, $rose(fwd_q), $past(frame_we), "forward without a write")
  `RSAB_ASSERT_NXT(a_s1_holds, res_vld && !s1_go, $stable(s1), "stalled stage lost its item")
  `RSAB_ASSERT_IMP(a_out_from_s1, $rose(m_axis_tvalid_o), $past(res_vld && s1_go), "result from nowhere")
  `RSAB_ASSERT_IMP(a_stall_cause, !s_axis_tready_o, m_axis_tvalid_o, "input stalled with output empty")

endmodule

// ===== rtl/rsab_ram.sv =====
module rsab_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port; read data holds while re_i is low.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/rsab_front.sv =====
module rsab_front #(
  parameter int FB_WIDTH_MAX  = 256,
  parameter int FB_HEIGHT_MAX = 256,
  parameter int AW            = $clog2(FB_WIDTH_MAX * FB_HEIGHT_MAX)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic               adv_i,
  input  logic [2:0]         mode_i,
  input  logic [7:0]         pal_index_i,
  input  logic [23:0]        color_value_i,
  input  logic [15:0]        pos_x_i,
  input  logic [15:0]        pos_y_i,
  input  logic [11:0]        sprite_width_i,
  input  logic [15:0]        data_word_i,
  input  logic [8:0]         target_width_i,
  input  logic [8:0]         target_height_i,
  output logic               pal_we_o,
  output logic [7:0]         pal_waddr_o,
  output logic [23:0]        pal_wdata_o,
  output logic [7:0]         pal_raddr_o,
  output logic [AW-1:0]      frame_raddr_o,
  output rsab_pkg::s1_t      s1_o,
  output logic [AW-1:0]      s1_addr_o
);
  import rsab_pkg::*;

  localparam int XW = $clog2(FB_WIDTH_MAX);
  localparam int YW = $clog2(FB_HEIGHT_MAX);
  localparam logic [16:0] FBW = 17'(FB_WIDTH_MAX);
  localparam logic [16:0] FBH = 17'(FB_HEIGHT_MAX);

  logic [17:0] cx_q, cx_d, cy_q, cy_d;
  logic [12:0] col_q, col_d;
  logic [11:0] rw_q, rw_d;
  logic [5:0]  left_q, left_d;
  logic [255:0] pal_vld_q;
  s1_t          s1_q, s1_d;
  logic [AW-1:0] addr_q;

  mode_e       mode;
  logic        hdr;
  logic [1:0]  kind;
  logic [5:0]  count;
  logic        is_skip;
  logic [17:0] pre_cx;
  logic [12:0] pre_col;
  logic        wrap;
  logic [17:0] w_cx, w_cy;
  logic [12:0] w_col;
  logic [17:0] lx, ly;
  logic [16:0] tw_eff, th_eff;
  logic        on_target;
  logic [AW-1:0] addr;

  assign mode  = mode_e'(mode_i);
  assign hdr   = (left_q == '0);
  assign kind  = data_word_i[15:14];
  assign count = data_word_i[5:0];
  assign is_skip = (mode == MODE_WORD) && hdr && (kind != KIND_PIXELS) && (kind != KIND_LINES);

  // A skip advances the cursor before the single wrap; a pixel wraps the current cursor.
  assign pre_cx  = is_skip ? cx_q + 18'(count) : cx_q;
  assign pre_col = is_skip ? col_q + 13'(count) : col_q;
  assign wrap    = pre_col >= {1'b0, rw_q};
  assign w_cx    = wrap ? pre_cx - 18'(rw_q) : pre_cx;
  assign w_cy    = wrap ? cy_q + 18'd1 : cy_q;
  assign w_col   = wrap ? pre_col - 13'(rw_q) : pre_col;

  // Pixel position: cursor for stream pixels, sign-extended position otherwise.
  assign lx = (mode == MODE_WORD) ? w_cx : {{2{pos_x_i[15]}}, pos_x_i};
  assign ly = (mode == MODE_WORD) ? w_cy : {{2{pos_y_i[15]}}, pos_y_i};

  // Target size saturated to the framebuffer size.
  assign tw_eff = (17'(target_width_i) > FBW) ? FBW : 17'(target_width_i);
  assign th_eff = (17'(target_height_i) > FBH) ? FBH : 17'(target_height_i);
  assign on_target = !lx[17] && !ly[17] && (lx[16:0] < tw_eff) && (ly[16:0] < th_eff);
  assign addr   = AW'(ly[YW-1:0]) * AW'(FB_WIDTH_MAX) + AW'(lx[XW-1:0]);

  // Stream decode, cursor update and the request for the second stage.
  always_comb begin
    cx_d   = cx_q;
    cy_d   = cy_q;
    col_d  = col_q;
    rw_d   = rw_q;
    left_d = left_q;
    s1_d         = '0;
    s1_d.op      = OP_NONE;
    s1_d.pix_x   = lx[7:0];
    s1_d.pix_y   = ly[7:0];
    s1_d.alpha   = data_word_i[12:9];
    s1_d.pal_idx = data_word_i[8:1];
    s1_d.pal_vld = pal_vld_q[data_word_i[8:1]];
    s1_d.color   = color_value_i;
    case (mode)
      MODE_START: begin
        cx_d   = {{2{pos_x_i[15]}}, pos_x_i};
        cy_d   = {{2{pos_y_i[15]}}, pos_y_i};
        col_d  = '0;
        rw_d   = sprite_width_i;
        left_d = '0;
      end
      MODE_WORD: begin
        if (hdr) begin
          if (kind == KIND_LINES) begin
            cy_d = cy_q + 18'(count);
          end else if (kind != KIND_PIXELS) begin
            cx_d  = w_cx;
            cy_d  = w_cy;
            col_d = w_col;
          end else begin
            left_d = count;
          end
        end else begin
          left_d  = left_q - 6'd1;
          cx_d    = w_cx + 18'd1;
          cy_d    = w_cy;
          col_d   = w_col + 13'd1;
          s1_d.op = on_target ? OP_BLEND : OP_NONE;
        end
      end
      MODE_READ: begin
        s1_d.op = on_target ? OP_READ : OP_NONE;
      end
      MODE_LOAD: begin
        s1_d.op = on_target ? OP_LOAD : OP_NONE;
      end
      default: begin
        s1_d.op = OP_NONE;
      end
    endcase
  end

  // Cursor and run state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q   <= '0;
      cy_q   <= '0;
      col_q  <= '0;
      rw_q   <= 12'd1;
      left_q <= '0;
    end else if (accept_i) begin
      cx_q   <= cx_d;
      cy_q   <= cy_d;
      col_q  <= col_d;
      rw_q   <= rw_d;
      left_q <= left_d;
    end
  end

  // Palette entries that were written; the others read as a grey ramp.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pal_vld_q <= '0;
    end else if (pal_we_o) begin
      pal_vld_q[pal_index_i] <= 1'b1;
    end
  end

  // Second stage register; a bubble enters when nothing is accepted.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
    end else if (adv_i) begin
      s1_q <= accept_i ? s1_d : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      addr_q <= addr;
    end
  end

  assign pal_we_o      = accept_i && (mode == MODE_PAL_WR);
  assign pal_waddr_o   = pal_index_i;
  assign pal_wdata_o   = color_value_i;
  assign pal_raddr_o   = data_word_i[8:1];
  assign frame_raddr_o = addr;
  assign s1_o          = s1_q;
  assign s1_addr_o     = addr_q;

endmodule

// ===== rtl/rsab_blend.sv =====
module rsab_blend (
  input  rsab_pkg::s1_t  s1_i,
  input  logic [23:0]    pal_rdata_i,
  input  logic [23:0]    frame_rdata_i,
  input  logic           fwd_i,
  input  logic [23:0]    fwd_data_i,
  output logic           wr_o,
  output logic [23:0]    wdata_o,
  output logic           res_vld_o,
  output rsab_pkg::res_t res_o
);
  import rsab_pkg::*;

  logic [23:0] pal;
  logic [23:0] dst;
  logic [23:0] mixed;

  // Unwritten palette entries hold the grey ramp; a framebuffer write issued with the read is forwarded.
  assign pal = s1_i.pal_vld ? pal_rdata_i : {3{s1_i.pal_idx}};
  assign dst = fwd_i ? fwd_data_i : frame_rdata_i;

  assign mixed = {mix8(dst[23:16], pal[23:16], s1_i.alpha),
                  mix8(dst[15:8],  pal[15:8],  s1_i.alpha),
                  mix8(dst[7:0],   pal[7:0],   s1_i.alpha)};

  // Framebuffer write for blends and loads.
  assign wr_o    = (s1_i.op == OP_BLEND) || (s1_i.op == OP_LOAD);
  assign wdata_o = (s1_i.op == OP_LOAD) ? s1_i.color : mixed;

  // Result for blends and reads.
  always_comb begin
    res_vld_o     = (s1_i.op == OP_BLEND) || (s1_i.op == OP_READ);
    res_o.pix_x   = s1_i.pix_x;
    res_o.pix_y   = s1_i.pix_y;
    res_o.is_read = (s1_i.op == OP_READ);
    {res_o.red, res_o.green, res_o.blue} = (s1_i.op == OP_READ) ? dst : mixed;
  end

endmodule

// ===== dv/rle_sprite_alpha_blitter_tb.sv =====
module rle_sprite_alpha_blitter_tb;
  import rsab_pkg::*;

  localparam int FB_W = 256;
  localparam int FB_H = 256;
  localparam int NUM_DIR = 28;
  localparam int NUM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 210;

  // Modes that the block ignores.
  localparam logic [2:0] MODE_UNK_LO = 3'd5;
  localparam logic [2:0] MODE_UNK_HI = 3'd7;

  // Both header kinds that mean a transparent skip.
  localparam logic [1:0] KIND_SKIP     = 2'b10;
  localparam logic [1:0] KIND_SKIP_ALT = 2'b11;

  // How a stimulus row is checked.
  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_RESULT
  } chk_e;

  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  pal_idx;
    logic [23:0] color;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [11:0] spr_w;
    logic [15:0] word;
  } blit_cmd_t;

  typedef struct packed {
    logic [7:0] pix_x;
    logic [7:0] pix_y;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       is_read;
  } pix_report_t;

  typedef struct packed {
    blit_cmd_t   cmd;
    chk_e        chk;
    pix_report_t res;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [95:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_ready = 1'b1;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_idx = '0;
  logic [8:0]  cfg_data = '0;

  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [39:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int err_count = 0;
  int tx_count = 0;

  // Blended pixels and read responses still owed by the block, oldest first.
  pix_report_t pixel_results_q[$];

  // Shadow copy of the blitter state.
  logic [23:0] pal_mem[256];
  logic [23:0] frame_mem[FB_W*FB_H];
  bit          frame_set[FB_W*FB_H];
  logic [17:0] cur_x = '0;
  logic [17:0] cur_y = '0;
  logic [12:0] col_cnt = '0;
  logic [11:0] run_w = 12'd1;
  logic [5:0]  px_left = '0;
  logic [8:0]  cfg_w = TARGET_RESET;
  logic [8:0]  cfg_h = TARGET_RESET;

  int phase_w[NUM_PHASES] = '{256, 1, 0, 511, 16, 200, 40, 256};
  int phase_h[NUM_PHASES] = '{256, 1, 200, 511, 20, 0, 12, 256};

  // Directed stimulus: field extremes, every mode and the corner cases of the stream.
  dir_row_t dir_tab[NUM_DIR] = '{
    '{'{MODE_LOAD,   8'h00, 24'hFFFFFF, 16'h0000, 16'h0000, 12'h000, 16'h0000}, CHK_NONE, '0},
    '{'{MODE_READ,   8'h00, 24'h000000, 16'h0000, 16'h0000, 12'h000, 16'h0000}, CHK_RESULT,
      '{8'd0, 8'd0, 8'hFF, 8'hFF, 8'hFF, 1'b1}},
    '{'{MODE_LOAD,   8'h00, 24'h000000, 16'h00FF, 16'h00FF, 12'h000, 16'h0000}, CHK_NONE, '0},
    '{'{MODE_READ,   8'h00, 24'h000000, 16'h00FF, 16'h00FF, 12'h000, 16'h0000}, CHK_RESULT,
      '{8'd255, 8'd255, 8'h00, 8'h00, 8'h00, 1'b1}},
    '{'{MODE_READ,   8'h00, 24'h000000, 16'hFFFF, 16'h0000, 12'h000, 16'h0000}, CHK_NONE, '0},
    '{'{MODE_LOAD,   8'h00, 24'hABCDEF, 16'h0100, 16'h0000, 12'h000, 16'h0000}, CHK_NONE, '0},
    '{'{MODE_READ,   8'h00, 24'h000000, 16'h7FFF, 16'h8000, 12'h000, 16'h0000}, CHK_NONE, '0},
    '{'{MODE_PAL_WR, 8'hFF, 24'h123456, 16'h0000, 16'h0000, 12'h000, 16'h0000}, CHK_NONE, '0},
    '{'{MODE_PAL_WR, 8'h00, 24'hABCDEF, 16'h0000, 16'h0000, 12'h000, 16'h0000}, CHK_NONE, '0},
    '{'{MODE_START,  8'h00, 24'h000000, 16'h0000, 16'h0000, 12'h002, 16'h0000}, CHK_NONE, '0},
    '{'{MODE_WORD,   8'h00, 24'h000000, 16'h0000, 16'h0000, 12'h000, 16'h0003}, CHK_NONE, '0},
    '{'{MODE_WORD,   8'h00, 24'h000000, 16'h0000, 16'h0000, 12'h000, 16'h1FFE}, CHK_MODEL, '0},
    '{'{MODE_WORD,   8'h00, 24'h000000, 16'h0000, 16'h0000, 12'h000, 16'h0000}, CHK_MODEL, '0},
    '{'{MODE_WORD,   8'h00, 24'h000000, 16'h0000, 16'h0000, 12'h000, 16'h1E00}, CHK_MODEL, '0},
    '{'{MODE_WORD,   8'h00, 24'h000000, 16'h0000, 16'h0000, 12'h000, 16'h0000}, CHK_NONE, '0},
    '{'{MODE_WORD,   8'h00, 24'h000000, 16'h0000, 16'h0000, 12'h000, 16'h8005}, CHK_NONE, '0},
    '{'{MODE_WORD,   8'h00, 24'h000000, 16'h0000, 16'h0000, 12'h000, 16'hC03F}, CHK_NONE, '0},
    '{'{MODE_WORD,   8'h00, 24'h000000, 16'h0000, 16'h0000, 12'h000, 16'h403F}, CHK_NONE, '0},
    '{'{MODE_START,  8'h00, 24'h000000, 16'h000A, 16'h000A, 12'h000, 16'h0000}, CHK_NONE, '0},
    '{'{MODE_WORD,   8'h00, 24'h000000, 16'h0000, 16'h0000, 12'h000, 16'h0002}, CHK_NONE, '0},
    '{'{MODE_WORD,   8'h00, 24'h000000, 16'h0000, 16'h0000, 12'h000, 16'h1FFE}, CHK_MODEL, '0},
    '{'{MODE_WORD,   8'h00, 24'h000000, 16'h0000, 16'h0000, 12'h000, 16'h1001}, CHK_MODEL, '0},
    '{'{MODE_WORD,   8'h00, 24'h000000, 16'h0000, 16'h0000, 12'h000, 16'h0005}, CHK_NONE, '0},
    '{'{MODE_WORD,   8'h00, 24'h000000, 16'h0000, 16'h0000, 12'h000, 16'h1FFE}, CHK_MODEL, '0},
    '{'{MODE_START,  8'h00, 24'h000000, 16'hFFFF, 16'hFFFF, 12'hFFF, 16'h0000}, CHK_NONE, '0},
    '{'{MODE_WORD,   8'h00, 24'h000000, 16'h0000, 16'h0000, 12'h000, 16'h0001}, CHK_NONE, '0},
    '{'{MODE_WORD,   8'h00, 24'h000000, 16'h0000, 16'h0000, 12'h000, 16'h1FFE}, CHK_NONE, '0},
    '{'{MODE_UNK_HI, 8'hFF, 24'hFFFFFF, 16'hFFFF, 16'hFFFF, 12'hFFF, 16'hFFFF}, CHK_NONE, '0}
  };

  rle_sprite_alpha_blitter DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  // Target size after saturation to the framebuffer size.
  function automatic int eff_size(logic [8:0] v, int lim);
    return (int'(v) > lim) ? lim : int'(v);
  endfunction

  // Frame index of a pixel, if it lies inside the current target.
  function automatic bit in_target(int x, int y, output int idx);
    idx = y * FB_W + x;
    return x >= 0 && y >= 0 && x < eff_size(cfg_w, FB_W) && y < eff_size(cfg_h, FB_H);
  endfunction

  // Cursor after the single column wrap that precedes a pixel or follows a skip.
  function automatic void wrap_spot(output logic [17:0] nx, output logic [17:0] ny,
                                    output logic [12:0] ncol);
    nx = cur_x;
    ny = cur_y;
    ncol = col_cnt;
    if (col_cnt >= 13'(run_w)) begin
      ny = cur_y + 18'd1;
      nx = cur_x - 18'(run_w);
      ncol = col_cnt - 13'(run_w);
    end
  endfunction

  function automatic logic [7:0] blend8(logic [7:0] d, logic [7:0] p, logic [3:0] a);
    int s;
    s = int'(d) * (15 - int'(a)) + int'(p) * int'(a);
    return 8'(s >> 4);
  endfunction

  // Applies one accepted transaction to the shadow state; returns 1 with its result.
  function automatic bit blit_predict(blit_cmd_t c, output pix_report_t r);
    int x, y, idx;
    logic [23:0] p, d, v;
    logic [3:0] a;
    bit made;
    r = '0;
    made = 1'b0;
    case (c.mode)
      MODE_PAL_WR: pal_mem[c.pal_idx] = c.color;
      MODE_START: begin
        cur_x = {{2{c.pos_x[15]}}, c.pos_x};
        cur_y = {{2{c.pos_y[15]}}, c.pos_y};
        col_cnt = '0;
        run_w = c.spr_w;
        px_left = '0;
      end
      MODE_READ, MODE_LOAD: begin
        x = int'($signed(c.pos_x));
        y = int'($signed(c.pos_y));
        if (in_target(x, y, idx)) begin
          if (c.mode == MODE_LOAD) begin
            frame_mem[idx] = c.color;
            frame_set[idx] = 1'b1;
          end else begin
            r = '{x[7:0], y[7:0], frame_mem[idx][23:16], frame_mem[idx][15:8],
                  frame_mem[idx][7:0], 1'b1};
            made = 1'b1;
          end
        end
      end
      MODE_WORD: begin
        if (px_left == 0) begin
          // Header word: blank lines, transparent skip or the length of a pixel run.
          if (c.word[15:14] == KIND_LINES) begin
            cur_y = cur_y + 18'(c.word[5:0]);
          end else if (c.word[15:14] != KIND_PIXELS) begin
            col_cnt = col_cnt + 13'(c.word[5:0]);
            cur_x = cur_x + 18'(c.word[5:0]);
            wrap_spot(cur_x, cur_y, col_cnt);
          end else begin
            px_left = c.word[5:0];
          end
        end else begin
          // Pixel word: blend the palette color into the frame at the cursor.
          px_left = px_left - 6'd1;
          wrap_spot(cur_x, cur_y, col_cnt);
          x = int'($signed(cur_x));
          y = int'($signed(cur_y));
          if (in_target(x, y, idx)) begin
            a = c.word[12:9];
            p = pal_mem[c.word[8:1]];
            d = frame_mem[idx];
            v = {blend8(d[23:16], p[23:16], a), blend8(d[15:8], p[15:8], a),
                 blend8(d[7:0], p[7:0], a)};
            frame_mem[idx] = v;
            r = '{x[7:0], y[7:0], v[23:16], v[15:8], v[7:0], 1'b0};
            made = 1'b1;
          end
          cur_x = cur_x + 18'd1;
          col_cnt = col_cnt + 13'd1;
        end
      end
      default: ;
    endcase
    return made;
  endfunction

  function automatic blit_cmd_t rand_base();
    blit_cmd_t c;
    c.mode = 3'($urandom);
    c.pal_idx = 8'($urandom);
    c.color = 24'($urandom);
    c.pos_x = 16'($urandom);
    c.pos_y = 16'($urandom);
    c.spr_w = 12'($urandom);
    c.word = 16'($urandom);
    return c;
  endfunction

  // Mostly near the target, so that pixels land on its edges; sometimes anywhere.
  function automatic logic [15:0] near_coord(int lim);
    if ($urandom_range(99) < 80)
      return 16'(int'($urandom_range(lim + 15)) - 8);
    return 16'($urandom);
  endfunction

  function automatic logic [11:0] sprite_span();
    int roll;
    roll = $urandom_range(99);
    if (roll < 60) return 12'($urandom_range(24, 1));
    if (roll < 70) return '0;
    if (roll < 85) return 12'($urandom_range(300, 25));
    return 12'($urandom);
  endfunction

  function automatic logic [5:0] header_count(int common_max);
    int roll;
    roll = $urandom_range(99);
    if (roll < 10) return '0;
    if (roll < 20) return 6'h3F;
    if (roll < 30) return 6'($urandom);
    return 6'($urandom_range(common_max, 1));
  endfunction

  // Random transaction, shaped as well-formed sprite streams with some noise between.
  function automatic blit_cmd_t rand_cmd();
    blit_cmd_t c;
    int roll;
    c = rand_base();
    roll = $urandom_range(99);
    if (px_left != 0) begin
      if (roll < 84) c.mode = MODE_WORD;
      else if (roll < 88) c.mode = MODE_START;
      else if (roll < 92) c.mode = MODE_PAL_WR;
      else if (roll < 97) c.mode = MODE_READ;
      else c.mode = MODE_LOAD;
    end else if (roll < 10) begin
      c.mode = MODE_START;
    end else if (roll < 55) begin
      c.mode = MODE_WORD;
      if (roll < 38) begin
        c.word[15:14] = KIND_PIXELS;
        c.word[5:0] = header_count(8);
      end else if (roll < 50) begin
        c.word[15:14] = ($urandom_range(1) != 0) ? KIND_SKIP : KIND_SKIP_ALT;
        c.word[5:0] = header_count(6);
      end else begin
        c.word[15:14] = KIND_LINES;
        c.word[5:0] = header_count(2);
      end
    end else if (roll < 65) begin
      c.mode = MODE_PAL_WR;
    end else if (roll < 77) begin
      c.mode = MODE_READ;
    end else if (roll < 85) begin
      c.mode = MODE_LOAD;
    end else if (roll < 89) begin
      c.mode = 3'($urandom_range(MODE_UNK_HI, MODE_UNK_LO));
    end else begin
      // Raw stream word of any kind.
      c.mode = MODE_WORD;
    end
    if (c.mode == MODE_START || c.mode == MODE_READ || c.mode == MODE_LOAD) begin
      c.pos_x = near_coord(eff_size(cfg_w, FB_W));
      c.pos_y = near_coord(eff_size(cfg_h, FB_H));
    end
    if (c.mode == MODE_START)
      c.spr_w = sprite_span();
    return c;
  endfunction

  // A frame pixel must be loaded before a read or a blend touches it.
  function automatic bit load_needed(blit_cmd_t c, output blit_cmd_t ld);
    int x, y, idx;
    logic [17:0] nx, ny;
    logic [12:0] ncol;
    ld = rand_base();
    ld.mode = MODE_LOAD;
    if (c.mode == MODE_READ) begin
      x = int'($signed(c.pos_x));
      y = int'($signed(c.pos_y));
    end else if (c.mode == MODE_WORD && px_left != 0) begin
      wrap_spot(nx, ny, ncol);
      x = int'($signed(nx));
      y = int'($signed(ny));
    end else begin
      return 1'b0;
    end
    if (!in_target(x, y, idx) || frame_set[idx])
      return 1'b0;
    ld.pos_x = x[15:0];
    ld.pos_y = y[15:0];
    return 1'b1;
  endfunction

  // Drives one input transaction and records what it should produce once accepted.
  task automatic send_cmd(blit_cmd_t c, chk_e chk, pix_report_t fixed_r);
    pix_report_t r;
    bit made;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {4'b0, c.word, c.spr_w, c.pos_y, c.pos_x, c.color, c.pal_idx};
    s_tuser <= c.mode;
    do @(posedge clk_i); while (!s_axis_tready_o);
    tx_count++;
    made = blit_predict(c, r);
    if (chk == CHK_RESULT)
      pixel_results_q.push_back(fixed_r);
    else if (chk == CHK_MODEL && made)
      pixel_results_q.push_back(r);
  endtask

  task automatic push_item(blit_cmd_t c, chk_e chk, pix_report_t fixed_r);
    blit_cmd_t ld;
    if (load_needed(c, ld))
      send_cmd(ld, CHK_MODEL, '0);
    send_cmd(c, chk, fixed_r);
  endtask

  // Writes both target registers once the block has drained.
  task automatic set_target(logic [8:0] w, logic [8:0] h);
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pixel_results_q.size() != 0) @(posedge clk_i);
    // Dropped pixels may still be in flight with no result to wait for.
    repeat (8) @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_TARGET_WIDTH;
    cfg_data <= w;
    @(posedge clk_i);
    cfg_w = w;
    cfg_idx <= CFG_TARGET_HEIGHT;
    cfg_data <= h;
    @(posedge clk_i);
    cfg_h = h;
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic cmp_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
      err_count++;
    end
  endtask

  // The receiver stalls at random according to the current phase.
  always @(posedge clk_i) begin
    m_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Compare each output transaction with the oldest expected result.
  always @(posedge clk_i) begin : result_check
    pix_report_t want;
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      if (pixel_results_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, got tdata %h tuser %b",
                 $time, m_axis_tdata_o, m_axis_tuser_o);
        err_count++;
      end else begin
        want = pixel_results_q.pop_front();
        cmp_field("pix_x", want.pix_x, m_axis_tdata_o[7:0]);
        cmp_field("pix_y", want.pix_y, m_axis_tdata_o[15:8]);
        cmp_field("red", want.red, m_axis_tdata_o[23:16]);
        cmp_field("green", want.green, m_axis_tdata_o[31:24]);
        cmp_field("blue", want.blue, m_axis_tdata_o[39:32]);
        cmp_field("is_read", 8'(want.is_read), 8'(m_axis_tuser_o));
      end
    end
  end

  initial begin
    blit_cmd_t c;
    int n;
    for (int i = 0; i < 256; i++)
      pal_mem[i] = {3{8'(i)}};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, at the reset target size and with no idling.
    foreach (dir_tab[i])
      push_item(dir_tab[i].cmd, dir_tab[i].chk, dir_tab[i].res);

    // Random part: one target setting and one idling pattern per phase.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p % 4)
        0: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
        1: begin tx_idle_pct = 63; rx_idle_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_idle_pct = 63; end
        default: begin tx_idle_pct = 34; rx_idle_pct = 34; end
      endcase
      if (p == NUM_PHASES - 1) begin
        phase_w[p] = $urandom_range(300, 1);
        phase_h[p] = $urandom_range(300, 1);
      end
      set_target(9'(phase_w[p]), 9'(phase_h[p]));
      // Every transaction counts, the inserted frame loads too.
      n = tx_count + ITEMS_PER_PHASE;
      while (tx_count < n) begin
        c = rand_cmd();
        push_item(c, CHK_MODEL, '0);
      end
    end

    // Drain the remaining results, then allow for the pipeline depth.
    s_tvalid <= 1'b0;
    while (pixel_results_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (err_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #3_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/rsab_pkg.sv
rtl/rsab_ram.sv
rtl/rsab_front.sv
rtl/rsab_blend.sv
rtl/rle_sprite_alpha_blitter.sv
dv/rle_sprite_alpha_blitter_tb.sv
